// ===== sv/stwt_pkg.sv =====
`default_nettype none
package stwt_pkg;

    localparam int SLOTS          = 16;
    localparam int THREAD_ID_BITS = 8;

    localparam int SLOT_IDX_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCAN_CNT_BITS  = $clog2(SLOTS + 1);

    localparam int TICK_BITS  = 32;
    localparam int DELAY_BITS = 24;
    localparam int ID_BITS    = 8;
    localparam int KIND_BITS  = 2;

    localparam logic       OP_SLEEP    = 1'b0;
    localparam logic       OP_TICK     = 1'b1;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_WAKE   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic                     sleep;
        logic                     tick;
        logic                     rd_en;
        logic [SLOT_IDX_BITS-1:0] rd_addr;
        logic                     chk_en;
        logic [SLOT_IDX_BITS-1:0] chk_addr;
        logic                     status;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== sv/stwt_ctrl.sv =====
`default_nettype none
module stwt_ctrl
    import stwt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_op,
    output t_dp_cmd   o_cmd,
    output logic      o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_STATUS
    } t_state;

    t_state                   r_state, n_state;
    logic [SCAN_CNT_BITS-1:0] r_idx, n_idx;
    logic [SCAN_CNT_BITS-1:0] idx_m1;
    logic                     accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;
    assign idx_m1 = r_idx - SCAN_CNT_BITS'(1);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_op == OP_TICK)) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (r_idx == SCAN_CNT_BITS'(SLOTS)) begin
                    n_state = S_STATUS;
                end else begin
                    n_idx = r_idx + SCAN_CNT_BITS'(1);
                end
            end
            S_STATUS: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // read slot k while checking slot k-1
    always_comb begin
        o_cmd.sleep    = accept && (i_op == OP_SLEEP);
        o_cmd.tick     = accept && (i_op == OP_TICK);
        o_cmd.rd_en    = (r_state == S_SCAN) && (r_idx != SCAN_CNT_BITS'(SLOTS));
        o_cmd.rd_addr  = r_idx[SLOT_IDX_BITS-1:0];
        o_cmd.chk_en   = (r_state == S_SCAN) && (r_idx != '0);
        o_cmd.chk_addr = idx_m1[SLOT_IDX_BITS-1:0];
        o_cmd.status   = (r_state == S_STATUS);
    end

    a_tick_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_TICK)) |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("tick accepted but scan did not start");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= SCAN_CNT_BITS'(SLOTS))
        else $error("scan index past table");

    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STATUS) |=> !o_busy)
        else $error("still busy after status");

endmodule
`default_nettype wire

// ===== sv/stwt_dp.sv =====
`default_nettype none
module stwt_dp
    import stwt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic [ID_BITS-1:0]    i_thread_id,
    input  wire logic [DELAY_BITS-1:0] i_delay,
    input  wire logic                  i_cpu_idle,
    input  wire logic                  i_future_pending,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_data,
    output logic                       o_strobe,
    output logic [KIND_BITS-1:0]       o_kind,
    output logic [ID_BITS-1:0]         o_woken_id,
    output logic                       o_table_full,
    output logic                       o_yield_request,
    output logic                       o_timer_off,
    output logic                       o_last
);

    logic [TICK_BITS-1:0]      mem_dl  [SLOTS];
    logic [THREAD_ID_BITS-1:0] mem_tid [SLOTS];

    logic [SLOTS-1:0]          r_valid;
    logic [TICK_BITS-1:0]      r_tick;
    logic                      r_pe;
    logic                      r_idle, r_fpend, r_woken;
    logic [TICK_BITS-1:0]      r_rd_dl;
    logic [THREAD_ID_BITS-1:0] r_rd_tid;

    logic                      r_strobe, n_strobe;
    logic [KIND_BITS-1:0]      r_kind, n_kind;
    logic [ID_BITS-1:0]        r_id, n_id;
    logic                      r_full, n_full;
    logic                      r_yield, n_yield;
    logic                      r_off, n_off;
    logic                      r_last, n_last;

    logic [SLOT_IDX_BITS-1:0]  free_idx;
    logic                      free_found;
    logic [TICK_BITS-1:0]      diff;
    logic                      wake;
    logic                      quiet;

    // lowest free slot
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx   = SLOT_IDX_BITS'(i);
                free_found = 1'b1;
            end
        end
    end

    assign diff  = r_tick - r_rd_dl;
    assign wake  = i_cmd.chk_en && r_valid[i_cmd.chk_addr] && !diff[TICK_BITS-1];
    assign quiet = r_idle && !r_woken && (r_valid == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sleep && free_found) begin
            mem_dl[free_idx]  <= r_tick + TICK_BITS'(i_delay);
            mem_tid[free_idx] <= THREAD_ID_BITS'(i_thread_id);
        end
        if (i_cmd.rd_en) begin
            r_rd_dl  <= mem_dl[i_cmd.rd_addr];
            r_rd_tid <= mem_tid[i_cmd.rd_addr];
        end
    end

    always_comb begin
        n_strobe = 1'b0;
        n_kind   = KIND_ACK;
        n_id     = '0;
        n_full   = 1'b0;
        n_yield  = 1'b0;
        n_off    = 1'b0;
        n_last   = 1'b0;
        if (i_cmd.sleep) begin
            n_strobe = 1'b1;
            n_full   = !free_found;
            n_last   = 1'b1;
        end else if (wake) begin
            n_strobe = 1'b1;
            n_kind   = KIND_WAKE;
            n_id     = ID_BITS'(r_rd_tid);
        end else if (i_cmd.status) begin
            n_strobe = 1'b1;
            n_kind   = KIND_STATUS;
            n_yield  = !quiet && r_pe;
            n_off    = quiet && !r_fpend;
            n_last   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_tick   <= '0;
            r_pe     <= 1'b1;
            r_woken  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_pe <= i_cfg_data;
            end
            if (i_cmd.sleep && free_found) begin
                r_valid[free_idx] <= 1'b1;
            end
            if (i_cmd.tick) begin
                r_tick  <= r_tick + TICK_BITS'(1);
                r_woken <= 1'b0;
            end
            if (wake) begin
                r_valid[i_cmd.chk_addr] <= 1'b0;
                r_woken                 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_idle  <= i_cpu_idle;
            r_fpend <= i_future_pending;
        end
        r_kind  <= n_kind;
        r_id    <= n_id;
        r_full  <= n_full;
        r_yield <= n_yield;
        r_off   <= n_off;
        r_last  <= n_last;
    end

    assign o_strobe        = r_strobe;
    assign o_kind          = r_kind;
    assign o_woken_id      = r_id;
    assign o_table_full    = r_full;
    assign o_yield_request = r_yield;
    assign o_timer_off     = r_off;
    assign o_last          = r_last;

    a_wake_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_kind == KIND_WAKE)) |-> !r_last)
        else $error("wake item flagged last");

    a_status_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.status |=> r_strobe && r_last && (r_kind == KIND_STATUS))
        else $error("status item missing");

    a_no_flags_on_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_kind == KIND_WAKE)) |-> !r_full && !r_yield && !r_off)
        else $error("status flags on wake item");

endmodule
`default_nettype wire

// ===== sv/sleep_timer_wakeup_table_unit.sv =====
`default_nettype none
// Channel   | Direction | Handshake                       | Payload
// ----------+-----------+---------------------------------+-----------------------------------
// command   | in        | start, busy (take: start&!busy) | i_op, i_thread_id, i_delay,
//           |           |                                 | i_cpu_idle, i_future_pending
// result    | out       | o_strobe (one cycle, no stall)  | o_kind, o_woken_id, o_table_full,
//           |           |                                 | o_yield_request, o_timer_off, o_last
// config    | in        | i_cfg_valid, o_cfg_ready        | i_cfg_data (preempt enable)
//
// A sleep item is taken when offered: its acknowledge shows on the next cycle and busy
// never rises, so sleep items can come back to back.
// A tick item holds busy for the scan and the status step: the slot table has one
// read port, so the scan reads one slot per cycle while comparing the previous one, and a
// final step builds the status item. Wake items come out in slot order during the scan.
// Reset (synchronous, active low) clears the tick count, empties the table and sets
// preempt enable. Results are never held off: each is on the ports for one cycle only.
// Register writes wait (o_cfg_ready low) while a tick is being scanned.
module sleep_timer_wakeup_table_unit
    import stwt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command item
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_op,
    input  wire logic [ID_BITS-1:0]    i_thread_id,
    input  wire logic [DELAY_BITS-1:0] i_delay,
    input  wire logic                  i_cpu_idle,
    input  wire logic                  i_future_pending,
    // result items
    output logic                       o_strobe,
    output logic [KIND_BITS-1:0]       o_kind,
    output logic [ID_BITS-1:0]         o_woken_id,
    output logic                       o_table_full,
    output logic                       o_yield_request,
    output logic                       o_timer_off,
    output logic                       o_last,
    // configuration
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_data
);

    t_dp_cmd cmd;

    // preempt enable only changes between ticks
    assign o_cfg_ready = !busy;

    stwt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    stwt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_thread_id      (i_thread_id),
        .i_delay          (i_delay),
        .i_cpu_idle       (i_cpu_idle),
        .i_future_pending (i_future_pending),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_kind           (o_kind),
        .o_woken_id       (o_woken_id),
        .o_table_full     (o_table_full),
        .o_yield_request  (o_yield_request),
        .o_timer_off      (o_timer_off),
        .o_last           (o_last)
    );

endmodule
`default_nettype wire
